### src/hsvrgb_pkg.sv
// Shared types and constants for the HSV to RGB pixel converter.
package hsvrgb_pkg;

  localparam logic [14:0] HUE_TURN   = 15'd23040;  // 360 degrees in 1/64 steps
  localparam logic [14:0] HUE_SECTOR = 15'd3840;   // 60 degrees in 1/64 steps
  localparam logic [12:0] Q12_ONE    = 13'd4096;
  localparam logic [20:0] CHAN_SCALE = 21'd255;
  localparam logic [20:0] HALF_Q12   = 21'd2048;
  // Level width for 1.0: Q12_ONE * HUE_SECTOR
  localparam logic [23:0] LEVEL_FULL = 24'd15728640;
  // Rounding bias: half of 2^24 * 3840, i.e. 15 * 2^31
  localparam logic [44:0] ROUND_BIAS = 45'd32212254720;
  // ceil(2^16 / 15) - 1, used as (m + 1) * RECIP15 >> 16 for m / 15
  localparam logic [12:0] RECIP15    = 13'd4369;

  typedef logic [2:0] sector_t;

  localparam sector_t SEC_RY = 3'd0;  // red to yellow
  localparam sector_t SEC_YG = 3'd1;  // yellow to green
  localparam sector_t SEC_GC = 3'd2;  // green to cyan
  localparam sector_t SEC_CB = 3'd3;  // cyan to blue
  localparam sector_t SEC_BM = 3'd4;  // blue to magenta
  localparam sector_t SEC_MR = 3'd5;  // magenta to red

  typedef struct packed {
    logic [14:0] hue;
    logic [12:0] saturation;
    logic [12:0] brightness;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_out_t;

  // Load enables for the two register stages inside a scaling lane
  typedef struct packed {
    logic prod_ld;
    logic coarse_ld;
  } lane_en_t;

endpackage

### src/hsvrgb_if.sv
// Valid/ready channel interfaces for pixel beats in and out.
interface hsvrgb_in_if;
  logic                  valid;
  logic                  ready;
  hsvrgb_pkg::pixel_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hsvrgb_out_if;
  logic                   valid;
  logic                   ready;
  hsvrgb_pkg::pixel_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/hsv_to_rgb_converter_unit.sv
// HSV to RGB pixel converter: five-stage pipeline, one pixel per clock unless the receiver stalls.
//
// in_chan carries one pixel per beat: hue in 1/64 degree (0..360, values
// above wrap once), saturation and brightness as Q1.12 (above 1.0 clamp).
// out_chan carries 8-bit red, green and blue, each rounded half up.
// Both channels are valid/ready; a beat moves when both are high.
//
// Throughput is one pixel per clock when the receiver keeps ready high; the
// stages are sector split, level widths, brightness multiply, rounding, and
// the divide by 15 plus channel select into the output register.
//
// Every stage has its own valid bit and advances when it is empty or the
// stage after it advances, so bubbles close up and a stalled receiver only
// holds the stages that are full. in_chan.ready drops only when all five
// stages hold a pixel. Nothing is stored between pixels.
//
// Synchronous reset clears all valid bits; the output is empty after reset.
module hsv_to_rgb_converter_unit (
  input  logic            clk,
  input  logic            rst_n,
  hsvrgb_in_if.sink       in_chan,
  hsvrgb_out_if.source    out_chan
);

  // stage 1: wrapped hue split into sector and position
  logic                  vld1_r;
  hsvrgb_pkg::sector_t   sec1_r;
  logic [11:0]           t1_r;
  logic [12:0]           sat1_r;
  logic [12:0]           val1_r;
  // stage 2: level widths
  logic                  vld2_r;
  hsvrgb_pkg::sector_t   sec2_r;
  logic [23:0]           wmid2_r;
  logic [23:0]           wlow2_r;
  logic [12:0]           val2_r;
  // stages 3 and 4: lanes hold products and coarse quotients
  logic                  vld3_r;
  hsvrgb_pkg::sector_t   sec3_r;
  logic [7:0]            full3_r;
  logic                  vld4_r;
  hsvrgb_pkg::sector_t   sec4_r;
  logic [7:0]            full4_r;
  // stage 5: output register
  logic                  vld5_r;
  hsvrgb_pkg::pixel_out_t out_r;
  hsvrgb_pkg::pixel_out_t out_nxt;

  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic ld1, ld2, ld3, ld4, ld5;

  logic [14:0]         hue_wrap;
  logic [12:0]         sat_clamp;
  logic [12:0]         val_clamp;
  logic [2:0]          sec_cnt;
  hsvrgb_pkg::sector_t sec_nxt;
  logic [14:0]         sec_base;
  logic [14:0]         frac_w;
  logic [14:0]         t_wide;
  logic [11:0]         t_nxt;
  logic [25:0]         wmid_sum;
  logic [25:0]         wlow_prod;
  logic [20:0]         full_sum;
  logic [7:0]          full_nxt;
  logic [7:0]          mid_chan;
  logic [7:0]          low_chan;
  hsvrgb_pkg::lane_en_t lane_en;

  // handshake: a stage takes a new beat when empty or draining
  assign rdy5 = !vld5_r || out_chan.ready;
  assign rdy4 = !vld4_r || rdy5;
  assign rdy3 = !vld3_r || rdy4;
  assign rdy2 = !vld2_r || rdy3;
  assign rdy1 = !vld1_r || rdy2;

  assign ld1 = rdy1 && in_chan.valid;
  assign ld2 = rdy2 && vld1_r;
  assign ld3 = rdy3 && vld2_r;
  assign ld4 = rdy4 && vld3_r;
  assign ld5 = rdy5 && vld4_r;

  assign in_chan.ready  = rdy1;
  assign out_chan.valid = vld5_r;
  assign out_chan.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      if (rdy1) vld1_r <= in_chan.valid;
      if (rdy2) vld2_r <= vld1_r;
      if (rdy3) vld3_r <= vld2_r;
      if (rdy4) vld4_r <= vld3_r;
      if (rdy5) vld5_r <= vld4_r;
    end
  end

  // stage 1 logic: clamp, wrap, split hue into sector and position
  always_comb begin
    sat_clamp = (in_chan.data.saturation > hsvrgb_pkg::Q12_ONE) ?
                hsvrgb_pkg::Q12_ONE : in_chan.data.saturation;
    val_clamp = (in_chan.data.brightness > hsvrgb_pkg::Q12_ONE) ?
                hsvrgb_pkg::Q12_ONE : in_chan.data.brightness;
    hue_wrap  = (in_chan.data.hue >= hsvrgb_pkg::HUE_TURN) ?
                in_chan.data.hue - hsvrgb_pkg::HUE_TURN : in_chan.data.hue;
    sec_cnt = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if (hue_wrap >= 15'(k) * hsvrgb_pkg::HUE_SECTOR) begin
        sec_cnt = sec_cnt + 3'd1;
      end
    end
    sec_nxt  = sec_cnt;
    sec_base = 15'(sec_cnt) * hsvrgb_pkg::HUE_SECTOR;
    frac_w   = hue_wrap - sec_base;
    // odd sectors fall from full to low
    t_wide   = sec_cnt[0] ? hsvrgb_pkg::HUE_SECTOR - frac_w : frac_w;
    t_nxt    = t_wide[11:0];
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      sec1_r <= sec_nxt;
      t1_r   <= t_nxt;
      sat1_r <= sat_clamp;
      val1_r <= val_clamp;
    end
  end

  // stage 2 logic: mid = S*t + (1-S)*sector, low = (1-S)*sector
  assign wlow_prod = 26'(hsvrgb_pkg::Q12_ONE - sat1_r) * 26'(hsvrgb_pkg::HUE_SECTOR);
  assign wmid_sum  = 26'(sat1_r) * 26'(t1_r) + wlow_prod;

  always_ff @(posedge clk) begin
    if (ld2) begin
      sec2_r  <= sec1_r;
      val2_r  <= val1_r;
      wmid2_r <= wmid_sum[23:0];
      wlow2_r <= wlow_prod[23:0];
    end
  end

  // full level needs no divide by 15: round V * 255 / 4096 directly
  assign full_sum = 21'(val2_r) * hsvrgb_pkg::CHAN_SCALE + hsvrgb_pkg::HALF_Q12;
  assign full_nxt = full_sum[19:12];

  assign lane_en.prod_ld   = ld3;
  assign lane_en.coarse_ld = ld4;

  hsvrgb_scale u_mid (
    .clk     (clk),
    .en      (lane_en),
    .value   (val2_r),
    .level_w (wmid2_r),
    .chan    (mid_chan)
  );

  hsvrgb_scale u_low (
    .clk     (clk),
    .en      (lane_en),
    .value   (val2_r),
    .level_w (wlow2_r),
    .chan    (low_chan)
  );

  always_ff @(posedge clk) begin
    if (ld3) begin
      sec3_r  <= sec2_r;
      full3_r <= full_nxt;
    end
    if (ld4) begin
      sec4_r  <= sec3_r;
      full4_r <= full3_r;
    end
  end

  // stage 5 logic: route full, mid and low by sector
  always_comb begin
    case (sec4_r)
      hsvrgb_pkg::SEC_RY: out_nxt = '{red: full4_r,  green: mid_chan, blue: low_chan};
      hsvrgb_pkg::SEC_YG: out_nxt = '{red: mid_chan, green: full4_r,  blue: low_chan};
      hsvrgb_pkg::SEC_GC: out_nxt = '{red: low_chan, green: full4_r,  blue: mid_chan};
      hsvrgb_pkg::SEC_CB: out_nxt = '{red: low_chan, green: mid_chan, blue: full4_r};
      hsvrgb_pkg::SEC_BM: out_nxt = '{red: mid_chan, green: low_chan, blue: full4_r};
      default:            out_nxt = '{red: full4_r,  green: low_chan, blue: mid_chan};
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      out_r <= out_nxt;
    end
  end

  // after reset the pipeline is empty
  assert property (@(posedge clk) !rst_n |=> !vld1_r && !vld5_r)
    else $error("pipeline not empty after reset");

  // position within a sector never exceeds one sector
  assert property (@(posedge clk) disable iff (!rst_n)
    vld1_r |-> (sec1_r <= hsvrgb_pkg::SEC_MR) && (12'(t1_r) <= 12'(hsvrgb_pkg::HUE_SECTOR)))
    else $error("sector split out of range");

  // level widths stay ordered: low <= mid <= full
  assert property (@(posedge clk) disable iff (!rst_n)
    vld2_r |-> (wlow2_r <= wmid2_r) && (wmid2_r <= hsvrgb_pkg::LEVEL_FULL))
    else $error("level widths out of order");

  // input stalls only when every stage holds a pixel
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> vld1_r && vld2_r && vld3_r && vld4_r && vld5_r)
    else $error("input stalled with an empty stage");

  // a stage that held a beat and could not drain still holds it
  assert property (@(posedge clk) disable iff (!rst_n)
    vld3_r && !rdy4 |=> vld3_r && $stable(sec3_r) && $stable(full3_r))
    else $error("stage 3 lost a beat under stall");

endmodule

### src/hsvrgb_scale.sv
// Scaling lane: turns brightness and a level width into an 8-bit channel.
module hsvrgb_scale (
  input  logic                 clk,
  input  hsvrgb_pkg::lane_en_t en,
  input  logic [12:0]          value,
  input  logic [23:0]          level_w,
  output logic [7:0]           chan
);

  logic [35:0] prod_r;
  logic [35:0] prod_nxt;
  logic [11:0] coarse_r;
  logic [11:0] coarse_nxt;
  logic [44:0] sum_w;
  logic [25:0] div_w;

  assign prod_nxt = 36'(37'(value) * 37'(level_w));

  // level * 255 + half, then drop the 2^32 part of the 15 * 2^32 divisor
  assign sum_w      = (45'(prod_r) << 8) - 45'(prod_r) + hsvrgb_pkg::ROUND_BIAS;
  assign coarse_nxt = sum_w[43:32];

  // divide by 15 through the reciprocal; exact for coarse values up to 3840
  assign div_w = (26'(coarse_r) + 26'd1) * 26'(hsvrgb_pkg::RECIP15);
  assign chan  = div_w[23:16];

  always_ff @(posedge clk) begin
    if (en.prod_ld) begin
      prod_r <= prod_nxt;
    end
    if (en.coarse_ld) begin
      coarse_r <= coarse_nxt;
    end
  end

endmodule

### dv/tb_hsv_to_rgb_converter_unit.sv
// Testbench for the HSV to RGB converter: directed and random pixel beats with a checker.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter_unit;

  localparam int unsigned RANDOM_PIXELS = 1500;
  localparam int unsigned DRAIN_AT      = 700;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam longint unsigned LEVEL_DEN = 64'd64424509440;  // 2^24 * 3840

  typedef struct {
    hsvrgb_pkg::pixel_in_t px;
    bit                    drain;  // hold this beat until every result is back
  } pixel_job_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hsvrgb_in_if  in_chan ();
  hsvrgb_out_if out_chan ();

  logic                  in_valid_r = 1'b0;
  hsvrgb_pkg::pixel_in_t in_data_r  = '0;
  logic                  out_ready_r = 1'b0;

  assign in_chan.valid  = in_valid_r;
  assign in_chan.data   = in_data_r;
  assign out_chan.ready = out_ready_r;

  pixel_job_t             pending_pixels[$];
  hsvrgb_pkg::pixel_out_t rgb_expected[$];
  int unsigned mismatch_count = 0;

  hsv_to_rgb_converter_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] level_to_byte(longint unsigned level);
    longint unsigned q;
    q = (level * 64'd255 + LEVEL_DEN / 2) / LEVEL_DEN;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic hsvrgb_pkg::pixel_out_t hsv_to_rgb(hsvrgb_pkg::pixel_in_t px);
    longint unsigned h, s, v, frac, ramp, full, low, mid, r, g, b;
    hsvrgb_pkg::sector_t sec;
    hsvrgb_pkg::pixel_out_t res;
    h = px.hue;
    s = (px.saturation > hsvrgb_pkg::Q12_ONE) ? hsvrgb_pkg::Q12_ONE : px.saturation;
    v = (px.brightness > hsvrgb_pkg::Q12_ONE) ? hsvrgb_pkg::Q12_ONE : px.brightness;
    if (h >= hsvrgb_pkg::HUE_TURN) h = h - hsvrgb_pkg::HUE_TURN;
    sec  = hsvrgb_pkg::sector_t'(h / hsvrgb_pkg::HUE_SECTOR);
    frac = h - sec * hsvrgb_pkg::HUE_SECTOR;
    ramp = sec[0] ? (hsvrgb_pkg::HUE_SECTOR - frac) : frac;
    full = v * hsvrgb_pkg::Q12_ONE * hsvrgb_pkg::HUE_SECTOR;
    low  = v * (hsvrgb_pkg::Q12_ONE - s) * hsvrgb_pkg::HUE_SECTOR;
    mid  = v * s * ramp + low;
    case (sec)
      hsvrgb_pkg::SEC_RY: begin r = full; g = mid;  b = low;  end
      hsvrgb_pkg::SEC_YG: begin r = mid;  g = full; b = low;  end
      hsvrgb_pkg::SEC_GC: begin r = low;  g = full; b = mid;  end
      hsvrgb_pkg::SEC_CB: begin r = low;  g = mid;  b = full; end
      hsvrgb_pkg::SEC_BM: begin r = mid;  g = low;  b = full; end
      default: begin r = full; g = low;  b = mid;  end
    endcase
    res.red   = level_to_byte(r);
    res.green = level_to_byte(g);
    res.blue  = level_to_byte(b);
    return res;
  endfunction

  task automatic queue_pixel(int unsigned h, int unsigned s, int unsigned v, bit drain);
    pixel_job_t job;
    job.px.hue        = h[14:0];
    job.px.saturation = s[12:0];
    job.px.brightness = v[12:0];
    job.drain         = drain;
    pending_pixels.push_back(job);
  endtask

  // Driver: present one beat at a time, idle a random gap after each (none in bursts).
  int unsigned in_gap = 0;
  bit          in_burst = 1'b0;

  always @(posedge clk) begin
    logic       nxt_valid;
    pixel_job_t job;
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      in_gap     <= 0;
    end else begin
      nxt_valid = in_valid_r;
      if (in_chan.valid && in_chan.ready) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
        end else if (pending_pixels.size() != 0 &&
                     !(pending_pixels[0].drain &&
                       (rgb_expected.size() != 0 || in_valid_r))) begin
          job = pending_pixels.pop_front();
          in_data_r <= job.px;
          nxt_valid = 1'b1;
          if ($urandom_range(0, 63) == 0) in_burst <= !in_burst;
          in_gap <= in_burst ? 0 : $urandom_range(0, 15);
        end
      end
      in_valid_r <= nxt_valid;
    end
  end

  // Monitor: predict on each input beat, check each output beat, stall at random.
  int unsigned out_stall = 0;
  bit          out_burst = 1'b0;

  always @(posedge clk) begin
    hsvrgb_pkg::pixel_out_t want;
    hsvrgb_pkg::pixel_out_t got;
    int unsigned            wait_n;
    if (!rst_n) begin
      out_ready_r <= 1'b0;
      out_stall   <= $urandom_range(0, 15);
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = out_chan.data;
        if (rgb_expected.size() == 0) begin
          $display("%0t: unexpected beat red=%0d green=%0d blue=%0d",
                   $time, got.red, got.green, got.blue);
          mismatch_count++;
        end else begin
          want = rgb_expected.pop_front();
          if (got.red !== want.red) begin
            $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
            mismatch_count++;
          end
          if (got.green !== want.green) begin
            $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
            mismatch_count++;
          end
          if (got.blue !== want.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
            mismatch_count++;
          end
        end
        if ($urandom_range(0, 63) == 0) out_burst <= !out_burst;
        wait_n = out_burst ? 0 : $urandom_range(0, 15);
        out_stall   <= wait_n;
        out_ready_r <= (wait_n == 0);
      end else if (!out_ready_r) begin
        if (out_stall > 1) begin
          out_stall <= out_stall - 1;
        end else begin
          out_stall   <= 0;
          out_ready_r <= 1'b1;
        end
      end
      if (in_chan.valid && in_chan.ready) rgb_expected.push_back(hsv_to_rgb(in_chan.data));
    end
  end

  initial begin
    int unsigned h, s, v;
    // corners and sector edges
    queue_pixel(0,     4096, 4096, 1'b0);
    queue_pixel(3839,  4096, 4096, 1'b0);
    queue_pixel(3840,  4096, 4096, 1'b0);
    queue_pixel(7679,  4096, 4096, 1'b0);
    queue_pixel(7680,  4096, 4096, 1'b0);
    queue_pixel(11520, 4096, 4096, 1'b0);
    queue_pixel(15360, 4096, 4096, 1'b0);
    queue_pixel(19200, 2048, 4096, 1'b0);
    queue_pixel(23039, 4096, 4096, 1'b0);
    queue_pixel(23040, 4096, 4096, 1'b0);  // full turn aliases to zero
    queue_pixel(23041, 3000, 3500, 1'b0);  // wraps once
    queue_pixel(32767, 4096, 4096, 1'b0);  // largest hue code
    queue_pixel(9727,  4096, 4096, 1'b0);
    queue_pixel(5000,  0,    4096, 1'b0);  // gray: no chroma
    queue_pixel(13000, 0,    2048, 1'b0);  // exact half, rounds up
    queue_pixel(17000, 4096, 0,    1'b0);  // black
    queue_pixel(2000,  8191, 8191, 1'b0);  // both clamp to one
    queue_pixel(21845, 5461, 2730, 1'b0);
    queue_pixel(10922, 2730, 5461, 1'b0);
    queue_pixel(1920,  4097, 4097, 1'b0);
    queue_pixel(16383, 4095, 4095, 1'b0);
    queue_pixel(16384, 1,    1,    1'b0);
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          h = $urandom_range(0, 32767);
          s = $urandom_range(0, 8191);
          v = $urandom_range(0, 8191);
        end
        2: begin
          // land near a sector boundary
          h = hsvrgb_pkg::HUE_SECTOR * $urandom_range(0, 6) + $urandom_range(0, 2);
          h = (h >= 2) ? h - 1 : h;
          s = $urandom_range(0, 1) ? 4096 : $urandom_range(0, 4096);
          v = $urandom_range(0, 1) ? 4096 : $urandom_range(0, 4096);
        end
        default: begin
          h = $urandom_range(0, 23040);
          s = $urandom_range(0, 4096);
          v = $urandom_range(0, 4096);
        end
      endcase
      queue_pixel(h, s, v, i == DRAIN_AT);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_pixels.size() != 0 || in_valid_r) @(posedge clk);
    while (rgb_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_hsv_to_rgb_converter_unit: PASS");
    end else begin
      $display("tb_hsv_to_rgb_converter_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout, %0d results outstanding", $time, rgb_expected.size());
    $display("tb_hsv_to_rgb_converter_unit: FAIL");
    $finish;
  end

endmodule

### filelist.f
src/hsvrgb_pkg.sv
src/hsvrgb_if.sv
src/hsvrgb_scale.sv
src/hsv_to_rgb_converter_unit.sv
dv/tb_hsv_to_rgb_converter_unit.sv
